@@ rtl/mkey_pkg.sv @@
`default_nettype none

package mkey_pkg;

   localparam int CHAR_W    = 8;
   localparam int TICKS_W   = 10;
   localparam int PAT_W     = 8;
   localparam int LEN_W     = 4;
   localparam int LEVEL_W   = 7;
   localparam int CSR_IDX_W = 2;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_DOT_TICKS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DASH_TICKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TICKS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACE_TICKS = 2'd3;

   localparam logic [TICKS_W-1:0] DOT_TICKS_RST   = 10'd10;
   localparam logic [TICKS_W-1:0] DASH_TICKS_RST  = 10'd30;
   localparam logic [TICKS_W-1:0] GAP_TICKS_RST   = 10'd10;
   localparam logic [TICKS_W-1:0] SPACE_TICKS_RST = 10'd20;

   // request kinds
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef struct packed {
      logic               led_on;
      logic               busy_res;
      logic               accepted;
      logic [LEVEL_W-1:0] queue_level;
   } mkey_rsp_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [CHAR_W-1:0] wdata;
   } mkey_qctl_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [PAT_W-1:0] pat;  // bit i set: element i is a dash
   } mkey_code_type;

   // Morse code ROM. A blank has no elements; unknown bytes give eight dots.
   function automatic mkey_code_type mkey_lookup(input logic [CHAR_W-1:0] c_in);
      logic [CHAR_W-1:0] c;
      mkey_code_type     r;
      c = c_in;
      if (c >= 8'h61 && c <= 8'h7A) begin
         c = c - 8'd32;
      end
      case (c)
         8'h20: r = '{len: 4'd0, pat: 8'h00};  // blank
         8'h41: r = '{len: 4'd2, pat: 8'h02};  // A
         8'h42: r = '{len: 4'd4, pat: 8'h01};
         8'h43: r = '{len: 4'd4, pat: 8'h05};
         8'h44: r = '{len: 4'd3, pat: 8'h01};
         8'h45: r = '{len: 4'd1, pat: 8'h00};
         8'h46: r = '{len: 4'd4, pat: 8'h04};
         8'h47: r = '{len: 4'd3, pat: 8'h03};
         8'h48: r = '{len: 4'd4, pat: 8'h00};
         8'h49: r = '{len: 4'd2, pat: 8'h00};
         8'h4A: r = '{len: 4'd4, pat: 8'h0E};
         8'h4B: r = '{len: 4'd3, pat: 8'h05};
         8'h4C: r = '{len: 4'd4, pat: 8'h02};
         8'h4D: r = '{len: 4'd2, pat: 8'h03};
         8'h4E: r = '{len: 4'd2, pat: 8'h01};
         8'h4F: r = '{len: 4'd3, pat: 8'h07};
         8'h50: r = '{len: 4'd4, pat: 8'h06};
         8'h51: r = '{len: 4'd4, pat: 8'h0B};
         8'h52: r = '{len: 4'd3, pat: 8'h02};
         8'h53: r = '{len: 4'd3, pat: 8'h00};
         8'h54: r = '{len: 4'd1, pat: 8'h01};
         8'h55: r = '{len: 4'd3, pat: 8'h04};
         8'h56: r = '{len: 4'd4, pat: 8'h08};
         8'h57: r = '{len: 4'd3, pat: 8'h06};
         8'h58: r = '{len: 4'd4, pat: 8'h09};
         8'h59: r = '{len: 4'd4, pat: 8'h0D};
         8'h5A: r = '{len: 4'd4, pat: 8'h03};  // Z
         8'h30: r = '{len: 4'd5, pat: 8'h1F};  // 0
         8'h31: r = '{len: 4'd5, pat: 8'h1E};
         8'h32: r = '{len: 4'd5, pat: 8'h1C};
         8'h33: r = '{len: 4'd5, pat: 8'h18};
         8'h34: r = '{len: 4'd5, pat: 8'h10};
         8'h35: r = '{len: 4'd5, pat: 8'h00};
         8'h36: r = '{len: 4'd5, pat: 8'h01};
         8'h37: r = '{len: 4'd5, pat: 8'h03};
         8'h38: r = '{len: 4'd5, pat: 8'h07};
         8'h39: r = '{len: 4'd5, pat: 8'h0F};  // 9
         8'h2E: r = '{len: 4'd6, pat: 8'h2A};  // .
         8'h2C: r = '{len: 4'd6, pat: 8'h33};  // ,
         8'h3A: r = '{len: 4'd6, pat: 8'h07};  // :
         8'h3B: r = '{len: 4'd6, pat: 8'h15};  // ;
         8'h3F: r = '{len: 4'd6, pat: 8'h0C};  // ?
         8'h2D: r = '{len: 4'd6, pat: 8'h21};  // -
         8'h5F: r = '{len: 4'd6, pat: 8'h2C};  // _
         8'h28: r = '{len: 4'd5, pat: 8'h0D};  // (
         8'h29: r = '{len: 4'd6, pat: 8'h2D};  // )
         8'h27: r = '{len: 4'd6, pat: 8'h1E};  // apostrophe
         8'h3D: r = '{len: 4'd5, pat: 8'h11};  // =
         8'h2B: r = '{len: 4'd5, pat: 8'h0A};  // +
         8'h2F: r = '{len: 4'd5, pat: 8'h09};  // /
         8'h40: r = '{len: 4'd6, pat: 8'h16};  // @
         default: r = '{len: 4'd8, pat: 8'h00};
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/mkey_ifs.sv @@
`default_nettype none

interface mkey_req_if import mkey_pkg::*;;
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, output req_type, output char_code, input ready);
   modport sink (input valid, input req_type, input char_code, output ready);
endinterface

interface mkey_rsp_if import mkey_pkg::*;;
   logic               valid;
   logic               ready;
   logic               led_on;
   logic               busy_res;
   logic               accepted;
   logic [LEVEL_W-1:0] queue_level;

   modport source (output valid, output led_on, output busy_res, output accepted,
                   output queue_level, input ready);
   modport sink (input valid, input led_on, input busy_res, input accepted,
                 input queue_level, output ready);
endinterface

`default_nettype wire

@@ rtl/mkey_queue.sv @@
`default_nettype none

module mkey_queue import mkey_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire mkey_qctl_type                ctl,
   output logic [CHAR_W-1:0]                 head_char,
   output logic [$clog2(DEPTH+1)-1:0]        count,
   output logic                              full
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

   logic [CHAR_W-1:0] mem [DEPTH];

   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CHAR_W-1:0] rd_ff;
   logic              fwd_ff;
   logic [CHAR_W-1:0] fwd_data_ff;
   logic [AW:0]       tail_sum;
   logic [AW-1:0]     tail;

   always_comb begin
      tail_sum = (AW + 1)'(head_ff) + (AW + 1)'(count_ff);
      if (tail_sum >= DEPTH_W) begin
         tail_sum = tail_sum - DEPTH_W;
      end
      tail = tail_sum[AW-1:0];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         head_in  = (head_ff == LAST) ? '0 : head_ff + AW'(1);
         count_in = count_ff - CW'(1);
      end else if (ctl.push) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         fwd_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         fwd_ff   <= ctl.push && (tail == head_in);
      end
   end

   // read the head of next cycle; a write to that entry this cycle is bypassed
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail] <= ctl.wdata;
      end
      rd_ff       <= mem[head_in];
      fwd_data_ff <= ctl.wdata;
   end

   assign head_char = fwd_ff ? fwd_data_ff : rd_ff;
   assign count     = count_ff;
   assign full      = (count_ff == CW'(DEPTH));

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> count_ff != '0)
      else $error("pop from empty queue");

   a_push_notfull: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> !full)
      else $error("push into full queue");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(ctl.push && ctl.pop))
      else $error("push and pop in one cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

@@ rtl/morse_keyer_core.sv @@
// Morse keyer core. Push beats load ASCII characters into a QUEUE_DEPTH-entry
// queue held in a synchronous RAM; tick beats advance the keying sequence by one
// timer tick. Every request beat produces exactly one response beat with the LED
// level, busy flag, push-accepted flag and queue level after that beat. One
// beat is taken every clock cycle while the skid is empty; the response is
// registered. The queue RAM has a registered read, so the head entry is
// prefetched every cycle and a push into the head slot is bypassed, letting a
// tick pop a character pushed the cycle before. A two-entry output stage
// (register plus skid) keeps requests flowing while a response waits. A full
// queue refuses a push (accepted low). No clearing pass is needed after reset.
`default_nettype none

module morse_keyer_core import mkey_pkg::*; #(
   parameter int QUEUE_DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   mkey_req_if.sink                  req_bus,
   mkey_rsp_if.source                rsp_bus,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TICKS_W-1:0]   csr_wdata
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_LIT   = 2'd1;
   localparam logic [1:0] PH_GAP   = 2'd2;
   localparam logic [1:0] PH_SPACE = 2'd3;

   logic [TICKS_W-1:0] dot_ff, dash_ff, gap_ff, space_ff;

   logic [1:0]         phase_ff, phase_in;
   logic [TICKS_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0]   elem_ff, elem_in;
   logic [PAT_W-1:0]   pat_ff, pat_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               led_ff, led_in;

   logic               rsp_valid_ff, skid_valid_ff;
   mkey_rsp_type       rsp_data_ff, skid_data_ff, result;

   mkey_qctl_type      qctl;
   logic [CHAR_W-1:0]  head_char;
   logic [CW-1:0]      q_count, q_count_after;
   logic               q_full;

   logic               in_acc, take;
   logic               adv, cont;
   logic [LEN_W-1:0]   ei, total, start_len;
   logic [TICKS_W-1:0] limit;
   mkey_code_type      code;

   assign in_acc        = req_bus.valid && req_bus.ready;
   assign take          = rsp_valid_ff && rsp_bus.ready;
   assign req_bus.ready = !skid_valid_ff;

   mkey_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (qctl),
      .head_char (head_char),
      .count     (q_count),
      .full      (q_full)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff   <= DOT_TICKS_RST;
         dash_ff  <= DASH_TICKS_RST;
         gap_ff   <= GAP_TICKS_RST;
         space_ff <= SPACE_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DOT_TICKS:   dot_ff   <= csr_wdata;
            CSR_DASH_TICKS:  dash_ff  <= csr_wdata;
            CSR_GAP_TICKS:   gap_ff   <= csr_wdata;
            CSR_SPACE_TICKS: space_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign code  = mkey_lookup(head_char);
   assign total = (len_ff == '0) ? LEN_W'(2) : len_ff + LEN_W'(1);

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      elem_in    = elem_ff;
      pat_in     = pat_ff;
      len_in     = len_ff;
      led_in     = led_ff;
      qctl.push  = 1'b0;
      qctl.pop   = 1'b0;
      qctl.wdata = req_bus.char_code;
      adv        = 1'b0;
      cont       = 1'b0;
      ei         = elem_ff;
      limit      = dot_ff;
      start_len  = len_ff;

      if (in_acc) begin
         if (req_bus.req_type == REQ_PUSH) begin
            qctl.push = !q_full;
         end else begin
            case (phase_ff)
               PH_LIT: begin
                  limit = pat_ff[elem_ff[2:0]] ? dash_ff : dot_ff;
                  if (cnt_ff >= limit) begin
                     phase_in = PH_GAP;
                     led_in   = 1'b0;
                     cnt_in   = TICKS_W'(1);
                  end else begin
                     cnt_in = cnt_ff + TICKS_W'(1);
                  end
               end
               PH_GAP, PH_SPACE: begin
                  limit = (phase_ff == PH_GAP) ? gap_ff : space_ff;
                  if (cnt_ff >= limit) begin
                     adv  = 1'b1;
                     cont = 1'b1;
                     ei   = elem_ff + LEN_W'(1);
                  end else begin
                     cnt_in = cnt_ff + TICKS_W'(1);
                  end
               end
               default: begin
                  adv = 1'b1;
               end
            endcase
         end
      end

      // next element of this character, else next queued character, else idle
      if (adv) begin
         if (cont && ei < total) begin
            elem_in = ei;
            cnt_in  = TICKS_W'(1);
         end else if (q_count != '0) begin
            qctl.pop  = 1'b1;
            pat_in    = code.pat;
            len_in    = code.len;
            start_len = code.len;
            ei        = '0;
            elem_in   = '0;
            cnt_in    = TICKS_W'(1);
         end else begin
            phase_in = PH_IDLE;
            led_in   = 1'b0;
            cnt_in   = '0;
            elem_in  = '0;
         end
         if ((cont && ei < total) || q_count != '0) begin
            if (ei < start_len) begin
               phase_in = PH_LIT;
               led_in   = 1'b1;
            end else begin
               phase_in = PH_SPACE;
               led_in   = 1'b0;
            end
         end
      end
   end

   always_comb begin
      q_count_after      = q_count + CW'(qctl.push) - CW'(qctl.pop);
      result.led_on      = led_in;
      result.busy_res    = (phase_in != PH_IDLE);
      result.accepted    = qctl.push;
      result.queue_level = LEVEL_W'(q_count_after);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         elem_ff  <= '0;
         pat_ff   <= '0;
         len_ff   <= '0;
         led_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         elem_ff  <= elem_in;
         pat_ff   <= pat_in;
         len_ff   <= len_in;
         led_ff   <= led_in;
      end
   end

   // output register plus skid; ready drops only when the skid holds a beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (in_acc) begin
            if (!rsp_valid_ff || take) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (take) begin
            rsp_valid_ff  <= skid_valid_ff;
            skid_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc) begin
         if (!rsp_valid_ff || take) begin
            rsp_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end else if (take && skid_valid_ff) begin
         rsp_data_ff <= skid_data_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.led_on      = rsp_data_ff.led_on;
   assign rsp_bus.busy_res    = rsp_data_ff.busy_res;
   assign rsp_bus.accepted    = rsp_data_ff.accepted;
   assign rsp_bus.queue_level = rsp_data_ff.queue_level;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a beat while output register is empty");

   a_idle_dark: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> !led_ff)
      else $error("LED lit while idle");

   a_lit_is_on: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LIT) == led_ff)
      else $error("LED level disagrees with keying phase");

   a_no_pop_on_push: assert property (@(posedge clock) disable iff (reset)
      (in_acc && req_bus.req_type == REQ_PUSH) |-> !qctl.pop)
      else $error("queue popped on a push beat");

endmodule

`default_nettype wire
